// ===== hdl/nfi_pkg.sv =====
// Shared types, widths and constants of the Newton forward interpolator.
package nfi_pkg;

  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int DATA_W  = 32;
  localparam int STEP_W  = 31;
  localparam int PCNT_W  = 5;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int DIFF_W  = 48;
  localparam int NUM_W   = DATA_W + 1 + FRAC_BITS;
  localparam int U_W     = DIFF_W;
  localparam int T_W     = 34;
  localparam int MA_W    = T_W - 1;
  localparam int PROD_W  = 64;
  localparam int ACC_W   = PROD_W + 1;
  localparam int SPAN_W  = CNT_W + STEP_W;
  localparam int MB_LO_W = DIFF_W / 2;
  localparam int MB_HI_W = DIFF_W - MB_LO_W;

  localparam int KQ_W     = 64;
  localparam int KD_STEP  = 8;
  localparam int KD_CYC   = KQ_W / KD_STEP;
  localparam int KD_CNT_W = $clog2(KD_CYC);

  localparam longint LIM_DIFF = (64'sd1 <<< (DIFF_W - 1)) - 64'sd1;
  localparam longint LIM_PROD = 64'sd1 <<< 62;
  localparam longint LIM_T    = (64'sd1 <<< 32) - 64'sd1;
  localparam longint LIM_U    = 64'sd1 <<< 46;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EVAL    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_X_ORIGIN    = 2'd0,
    REG_STEP_H      = 2'd1,
    REG_POINT_COUNT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [MA_W-1:0]   a;
    logic [DIFF_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic                     sat;
    logic signed [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

// ===== hdl/nfi_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module nfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/nfi_div.sv =====
// Restoring divider, one quotient bit per cycle, for the normalized offset u.
module nfi_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nfi_pkg::NUM_W-1:0] dividend,
  input  logic [nfi_pkg::STEP_W-1:0] divisor,
  output logic                      done,
  output logic [nfi_pkg::NUM_W-1:0] quotient
);

  localparam int CW = $clog2(nfi_pkg::NUM_W + 1);

  logic                        run;
  logic [CW-1:0]               cnt;
  logic [nfi_pkg::STEP_W-1:0]  rem;
  logic [nfi_pkg::STEP_W-1:0]  dvs;
  logic [nfi_pkg::STEP_W:0]    trial;
  logic                        qbit;

  always_comb begin
    trial = {rem, quotient[nfi_pkg::NUM_W-1]};
    qbit  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= CW'(nfi_pkg::NUM_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        // shift one dividend bit in, subtract when it fits
        rem      <= qbit ? nfi_pkg::STEP_W'(trial - {1'b0, dvs})
                         : trial[nfi_pkg::STEP_W-1:0];
        quotient <= {quotient[nfi_pkg::NUM_W-2:0], qbit};
        cnt      <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/nfi_mul.sv =====
// Three-stage magnitude multiplier with half-up rounding, clipping and sign.
module nfi_mul (
  input  logic              clk,
  input  logic              rst,
  input  nfi_pkg::mul_req_t req,
  output nfi_pkg::mul_rsp_t rsp
);

  localparam int LO_W = nfi_pkg::MA_W + nfi_pkg::MB_LO_W;
  localparam int PF_W = nfi_pkg::MA_W + nfi_pkg::DIFF_W + 1;

  logic                      v1, v2, v3;
  logic                      neg;
  logic [nfi_pkg::MA_W-1:0]  ra;
  logic [nfi_pkg::DIFF_W-1:0] rb;
  logic [LO_W-1:0]           plo;
  logic [PF_W-1:0]           pfull;
  logic [PF_W-1:0]           rnd;
  logic                      over;
  logic [nfi_pkg::PROD_W-1:0] mag;
  logic                      done_q;
  logic                      sat_q;
  logic signed [nfi_pkg::PROD_W-1:0] product_q;

  always_comb begin
    rnd  = (pfull + (PF_W'(1) << (nfi_pkg::FRAC_BITS - 1))) >> nfi_pkg::FRAC_BITS;
    over = (rnd > PF_W'(nfi_pkg::LIM_PROD));
    mag  = over ? nfi_pkg::PROD_W'(nfi_pkg::LIM_PROD) : rnd[nfi_pkg::PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1     <= req.start;
      v2     <= v1;
      v3     <= v2;
      done_q <= v3;
    end
    if (req.start) begin
      ra  <= req.a;
      rb  <= req.b;
      neg <= req.neg;
    end
    if (v1) begin
      plo <= LO_W'(LO_W'(ra) * LO_W'(rb[nfi_pkg::MB_LO_W-1:0]));
    end
    if (v2) begin
      pfull <= PF_W'(plo) + (PF_W'(LO_W'(ra) * LO_W'(rb[nfi_pkg::DIFF_W-1:nfi_pkg::MB_LO_W]))
                             << nfi_pkg::MB_LO_W);
    end
    if (v3) begin
      sat_q     <= over;
      product_q <= neg ? -$signed(mag) : $signed(mag);
    end
  end

  assign rsp = {v1 | v2 | v3 | done_q, done_q, sat_q, product_q};

endmodule

// ===== hdl/newton_forward_interpolator_unit.sv =====
// Newton forward-difference interpolator: samples y0..y(n-1) at spacing h are loaded one
// transfer at a time (opcode load), building the newest difference diagonal and the leading
// coefficients D^k y0 in two 16-entry RAMs; an evaluate transfer returns the Q16.16 sum
// D^k y0 * u(u-1)..(u-k+1)/k! with u = (x - x0)/h, a range flag and a clip flag; restart
// clears the sample count. busy stays high while an item is worked on; start is taken only
// while busy is low. Each result appears for exactly one cycle with done high and must be
// captured then, since the block cannot be held off. A load of sample m reads and then writes
// each diagonal entry 0..m in turn through the diagonal RAM (states S_LD_RD, S_LD_WR). An evaluate
// first runs the bit-serial u = (x-x0)/h division; then per term it multiplies t by u-(k-1),
// divides by k at eight quotient bits a cycle, clips t and multiplies t by D^k y0, each product
// a pass through the three-stage multiplier with issue and wait. A final step clips and presents
// the result. A query before n samples are loaded, restart and unknown opcodes finish at once;
// only evaluate produces a result.
module newton_forward_interpolator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] x_value,
  input  logic [31:0] y_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output logic        done,
  output logic [31:0] y_result,
  output logic        extrapolated,
  output logic        saturated,
  output logic        status
);

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_WR, S_EV_C0, S_EV_DIV, S_EV_M1, S_EV_M1W,
    S_EV_KD, S_EV_TC, S_EV_M2, S_EV_M2W, S_EV_FIN
  } state_t;

  localparam int DW = nfi_pkg::DIFF_W;
  localparam int AW = nfi_pkg::ADDR_W;
  localparam int CW = nfi_pkg::CNT_W;

  state_t state;

  // configuration
  logic signed [nfi_pkg::DATA_W-1:0] x_origin;
  logic [nfi_pkg::STEP_W-1:0]        step_h;
  logic [nfi_pkg::PCNT_W-1:0]        point_count;

  // control and working registers
  logic [CW-1:0]                     loaded;
  logic [AW-1:0]                     k;
  logic [AW-1:0]                     m;
  logic signed [nfi_pkg::DATA_W-1:0] yin;
  logic signed [DW-1:0]              newprev;
  logic signed [DW-1:0]              oldprev;
  logic signed [nfi_pkg::DATA_W:0]   dx;
  logic                              ext;
  logic                              sat;
  logic signed [nfi_pkg::U_W-1:0]    u;
  logic signed [nfi_pkg::T_W-1:0]    t;
  logic                              tneg;
  logic signed [nfi_pkg::ACC_W-1:0]  acc;
  logic [nfi_pkg::KQ_W-1:0]          kq;
  logic [AW-1:0]                     krem;
  logic [nfi_pkg::KD_CNT_W-1:0]      kd_cnt;

  // combinational
  logic [CW-1:0]                     n_eff;
  logic                              tbl_ready;
  logic                              accept;
  logic [nfi_pkg::STEP_W-1:0]        h_eff;
  logic signed [nfi_pkg::DATA_W:0]   dx_in;
  logic [nfi_pkg::DATA_W:0]          dx_mag;
  logic [nfi_pkg::SPAN_W-1:0]        span;
  logic                              ext_in;
  logic signed [DW:0]                dd;
  logic signed [DW-1:0]              newv;
  logic signed [DW:0]                f;
  logic [DW:0]                       f_mag;
  logic [nfi_pkg::T_W-1:0]           t_mag;
  logic [DW-1:0]                     c_mag;
  logic [nfi_pkg::KQ_W-1:0]          kq_next;
  logic [AW-1:0]                     krem_next;
  logic [AW:0]                       ktrial;
  logic [nfi_pkg::PROD_W-1:0]        p_mag;
  logic [nfi_pkg::MA_W-1:0]          tm_cl;
  logic                              t_over;
  logic signed [nfi_pkg::ACC_W-1:0]  acc_sum;
  logic signed [nfi_pkg::ACC_W-1:0]  acc_cl;
  logic                              acc_over;
  logic [nfi_pkg::NUM_W-1:0]         q_cl;
  logic                              q_over;

  // memories and units
  logic                              diag_we;
  logic [DW-1:0]                     diag_rdata;
  logic                              coef_we;
  logic [AW-1:0]                     coef_raddr;
  logic [DW-1:0]                     coef_rdata;
  logic                              div_start;
  logic [nfi_pkg::NUM_W-1:0]         div_q;
  logic                              div_done;
  nfi_pkg::mul_req_t                 mul_req;
  nfi_pkg::mul_rsp_t                 mul_rsp;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // configuration writes land directly; no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin    <= '0;
      step_h      <= nfi_pkg::STEP_W'(65536);
      point_count <= nfi_pkg::PCNT_W'(16);
    end else if (cfg_we) begin
      case (nfi_pkg::reg_index_t'(cfg_addr))
        nfi_pkg::REG_X_ORIGIN:    x_origin    <= $signed(cfg_wdata);
        nfi_pkg::REG_STEP_H:      step_h      <= cfg_wdata[nfi_pkg::STEP_W-1:0];
        nfi_pkg::REG_POINT_COUNT: point_count <= cfg_wdata[nfi_pkg::PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // clamp the point count into 1..MAX_POINTS
    if (point_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(point_count) > nfi_pkg::MAX_POINTS) begin
      n_eff = CW'(nfi_pkg::MAX_POINTS);
    end else begin
      n_eff = CW'(point_count);
    end
    tbl_ready = (loaded >= n_eff);
    h_eff     = (step_h == '0) ? nfi_pkg::STEP_W'(1) : step_h;

    // offset from x0 and the range check against (n-1)*h
    dx_in  = $signed({x_value[31], x_value}) - $signed({x_origin[31], x_origin});
    dx_mag = dx_in[nfi_pkg::DATA_W] ? (nfi_pkg::DATA_W+1)'(-dx_in)
                                    : (nfi_pkg::DATA_W+1)'(dx_in);
    span   = nfi_pkg::SPAN_W'(nfi_pkg::SPAN_W'(n_eff - CW'(1)) * nfi_pkg::SPAN_W'(h_eff));
    ext_in = dx_in[nfi_pkg::DATA_W] || (nfi_pkg::SPAN_W'(dx_in[nfi_pkg::DATA_W-1:0]) > span);

    // next diagonal entry: new[k] = new[k-1] - old[k-1], clipped
    dd = $signed({newprev[DW-1], newprev}) - $signed({oldprev[DW-1], oldprev});
    if (k == '0) begin
      newv = DW'(yin);
    end else if (dd > (DW+1)'(nfi_pkg::LIM_DIFF)) begin
      newv = DW'(nfi_pkg::LIM_DIFF);
    end else if (dd < -(DW+1)'(nfi_pkg::LIM_DIFF)) begin
      newv = -DW'(nfi_pkg::LIM_DIFF);
    end else begin
      newv = dd[DW-1:0];
    end

    // factor u - (k-1) and operand magnitudes for the multiplier
    f     = $signed({u[nfi_pkg::U_W-1], u}) - $signed((DW+1)'(k - AW'(1)) << nfi_pkg::FRAC_BITS);
    f_mag = f[DW] ? (DW+1)'(-f) : (DW+1)'(f);
    t_mag = t[nfi_pkg::T_W-1] ? nfi_pkg::T_W'(-t) : nfi_pkg::T_W'(t);
    c_mag = coef_rdata[DW-1] ? DW'(-$signed(coef_rdata)) : coef_rdata;

    mul_req.start = (state == S_EV_M1) || (state == S_EV_M2);
    mul_req.a     = t_mag[nfi_pkg::MA_W-1:0];
    if (state == S_EV_M1) begin
      mul_req.b   = f_mag[DW-1:0];
      mul_req.neg = t[nfi_pkg::T_W-1] ^ f[DW];
    end else begin
      mul_req.b   = c_mag;
      mul_req.neg = t[nfi_pkg::T_W-1] ^ coef_rdata[DW-1];
    end

    p_mag = mul_rsp.product[nfi_pkg::PROD_W-1] ? nfi_pkg::PROD_W'(-mul_rsp.product)
                                               : nfi_pkg::PROD_W'(mul_rsp.product);

    // division by k: eight quotient bits per cycle on a narrow remainder
    kq_next   = kq;
    krem_next = krem;
    for (int i = 0; i < nfi_pkg::KD_STEP; i++) begin
      ktrial  = {krem_next, kq_next[nfi_pkg::KQ_W-1]};
      kq_next = {kq_next[nfi_pkg::KQ_W-2:0], 1'b0};
      if (ktrial >= {1'b0, k}) begin
        krem_next  = AW'(ktrial - {1'b0, k});
        kq_next[0] = 1'b1;
      end else begin
        krem_next  = ktrial[AW-1:0];
      end
    end
    t_over = (kq > nfi_pkg::KQ_W'(nfi_pkg::LIM_T));
    tm_cl  = t_over ? nfi_pkg::MA_W'(nfi_pkg::LIM_T) : kq[nfi_pkg::MA_W-1:0];

    // accumulate with clip at 2^62
    acc_sum  = acc + nfi_pkg::ACC_W'(mul_rsp.product);
    acc_over = 1'b0;
    acc_cl   = acc_sum;
    if (acc_sum > nfi_pkg::ACC_W'(nfi_pkg::LIM_PROD)) begin
      acc_cl   = nfi_pkg::ACC_W'(nfi_pkg::LIM_PROD);
      acc_over = 1'b1;
    end else if (acc_sum < -nfi_pkg::ACC_W'(nfi_pkg::LIM_PROD)) begin
      acc_cl   = -nfi_pkg::ACC_W'(nfi_pkg::LIM_PROD);
      acc_over = 1'b1;
    end

    q_over = (div_q > nfi_pkg::NUM_W'(nfi_pkg::LIM_U));
    q_cl   = q_over ? nfi_pkg::NUM_W'(nfi_pkg::LIM_U) : div_q;

    div_start  = accept && (nfi_pkg::opcode_t'(opcode) == nfi_pkg::OP_EVAL) && tbl_ready;
    diag_we    = (state == S_LD_WR);
    coef_we    = (state == S_LD_WR) && (k == m);
    coef_raddr = (state == S_IDLE) ? '0 : k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      loaded   <= '0;
      done     <= 1'b0;
      y_result <= '0;
      extrapolated <= 1'b0;
      saturated    <= 1'b0;
      status       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (nfi_pkg::opcode_t'(opcode))
              nfi_pkg::OP_RESTART: loaded <= '0;
              nfi_pkg::OP_LOAD: begin
                // drop the sample once the table is full
                if (!tbl_ready) begin
                  m     <= AW'(loaded);
                  k     <= '0;
                  yin   <= $signed(y_value);
                  state <= S_LD_RD;
                end
              end
              nfi_pkg::OP_EVAL: begin
                if (!tbl_ready) begin
                  done         <= 1'b1;
                  y_result     <= '0;
                  extrapolated <= 1'b0;
                  saturated    <= 1'b0;
                  status       <= 1'b1;
                end else begin
                  dx    <= dx_in;
                  ext   <= ext_in;
                  sat   <= 1'b0;
                  state <= S_EV_C0;
                end
              end
              default: ;
            endcase
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: begin
          if (k == m) begin
            loaded <= loaded + CW'(1);
            state  <= S_IDLE;
          end else begin
            newprev <= newv;
            oldprev <= $signed(diag_rdata);
            k       <= k + AW'(1);
            state   <= S_LD_RD;
          end
        end
        S_EV_C0: begin
          acc   <= nfi_pkg::ACC_W'($signed(coef_rdata));
          t     <= nfi_pkg::T_W'(64'sd1 <<< nfi_pkg::FRAC_BITS);
          state <= S_EV_DIV;
        end
        S_EV_DIV: begin
          if (div_done) begin
            // clipping u only matters when a term uses it
            if (q_over && (n_eff >= CW'(2))) begin
              sat <= 1'b1;
            end
            u     <= dx[nfi_pkg::DATA_W] ? -nfi_pkg::U_W'(q_cl) : nfi_pkg::U_W'(q_cl);
            k     <= AW'(1);
            state <= (n_eff == CW'(1)) ? S_EV_FIN : S_EV_M1;
          end
        end
        S_EV_M1: state <= S_EV_M1W;
        S_EV_M1W: begin
          if (mul_rsp.done) begin
            sat    <= sat | mul_rsp.sat;
            tneg   <= mul_rsp.product[nfi_pkg::PROD_W-1];
            kq     <= p_mag + nfi_pkg::KQ_W'(k >> 1);
            krem   <= '0;
            kd_cnt <= nfi_pkg::KD_CNT_W'(nfi_pkg::KD_CYC - 1);
            state  <= S_EV_KD;
          end
        end
        S_EV_KD: begin
          kq     <= kq_next;
          krem   <= krem_next;
          kd_cnt <= kd_cnt - nfi_pkg::KD_CNT_W'(1);
          if (kd_cnt == '0) begin
            state <= S_EV_TC;
          end
        end
        S_EV_TC: begin
          if (t_over) begin
            sat <= 1'b1;
          end
          t     <= tneg ? -$signed({1'b0, tm_cl}) : $signed({1'b0, tm_cl});
          state <= S_EV_M2;
        end
        S_EV_M2: state <= S_EV_M2W;
        S_EV_M2W: begin
          if (mul_rsp.done) begin
            acc <= acc_cl;
            sat <= sat | mul_rsp.sat | acc_over;
            if (CW'(k) == n_eff - CW'(1)) begin
              state <= S_EV_FIN;
            end else begin
              k     <= k + AW'(1);
              state <= S_EV_M1;
            end
          end
        end
        S_EV_FIN: begin
          // final clip into 32-bit signed
          if (acc > nfi_pkg::ACC_W'(33'sh0_7FFF_FFFF)) begin
            y_result  <= 32'h7FFF_FFFF;
            saturated <= 1'b1;
          end else if (acc < -nfi_pkg::ACC_W'(33'sh0_8000_0000)) begin
            y_result  <= 32'h8000_0000;
            saturated <= 1'b1;
          end else begin
            y_result  <= acc[31:0];
            saturated <= sat;
          end
          extrapolated <= ext;
          status       <= 1'b0;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  nfi_ram #(.WIDTH(DW), .DEPTH(nfi_pkg::MAX_POINTS)) u_diag_ram (
    .clk   (clk),
    .we    (diag_we),
    .waddr (k),
    .wdata (newv),
    .raddr (k),
    .rdata (diag_rdata)
  );

  nfi_ram #(.WIDTH(DW), .DEPTH(nfi_pkg::MAX_POINTS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (m),
    .wdata (newv),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  nfi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({dx_mag, nfi_pkg::FRAC_BITS'(0)}),
    .divisor  (h_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  nfi_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

`ifndef SYNTHESIS
  a_not_ready_clean: assert property (@(posedge clk) disable iff (rst)
    done && status |-> (y_result == '0) && !extrapolated && !saturated)
    else $error("not-ready result carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(loaded) <= nfi_pkg::MAX_POINTS)
    else $error("sample count beyond table depth");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (opcode == nfi_pkg::OP_LOAD) && !tbl_ready |=> busy)
    else $error("accepted load did not start");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a transfer");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the Newton forward-difference interpolator unit.
`timescale 1ns / 1ps

module tb;
  import nfi_pkg::*;

  localparam int     SETTLE_CYCLES = 400;       // longer than the slowest evaluate
  localparam longint CYCLE_LIMIT   = 4000000;

  typedef struct {
    logic [31:0] y;
    bit          ext;
    bit          sat;
    bit          not_ready;
  } interp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = OP_LOAD;
  logic [31:0] x_value = '0;
  logic [31:0] y_value = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_X_ORIGIN;
  logic [31:0] cfg_wdata = '0;
  logic        done;
  logic [31:0] y_result;
  logic        extrapolated;
  logic        saturated;
  logic        status;

  newton_forward_interpolator_unit uut (.*);

  always #2 clk = ~clk;

  // Shadow copy of the block's registers and tables.
  longint      shadow_x0;
  longint      shadow_h;
  int          shadow_count;
  int          shadow_loaded;
  longint      shadow_diag [MAX_POINTS];
  longint      shadow_coef [MAX_POINTS];

  interp_result_t pending_results[$];
  int          mismatches = 0;
  int          idle_pct = 0;
  longint      cycles = 0;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clamp(longint v, longint lim, inout bit sat);
    if (v > lim) begin
      sat = 1'b1;
      return lim;
    end
    if (v < -lim) begin
      sat = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  // Rounded Q16.16 product of magnitudes, split so no partial product overflows.
  function automatic longint unsigned q_mul_mag(longint unsigned a, longint unsigned b,
                                                inout bit sat);
    longint unsigned lim, hi, lo;
    lim = LIM_PROD;
    hi = a * (b >> 24);
    lo = (a * (b & 64'hFFFFFF) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (hi > (lim >> (24 - FRAC_BITS))) begin
      sat = 1'b1;
      return lim;
    end
    hi = hi << (24 - FRAC_BITS);
    if (hi + lo > lim) begin
      sat = 1'b1;
      return lim;
    end
    return hi + lo;
  endfunction

  function automatic longint q_mul(longint a, longint b, inout bit sat);
    longint r;
    r = q_mul_mag(magnitude(a), magnitude(b), sat);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic int active_points();
    int n;
    n = shadow_count;
    if (n == 0) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    return n;
  endfunction

  // Fold one new sample into the newest diagonal and record the next coefficient.
  function automatic void absorb_sample(logic [31:0] yv);
    int     m;
    longint prev, cur;
    bit     unused;
    m = shadow_loaded;
    unused = 1'b0;
    if (m >= active_points()) return;
    prev = shadow_diag[0];
    shadow_diag[0] = sx32(yv);
    for (int k = 1; k <= m; k++) begin
      cur = (k < m) ? shadow_diag[k] : 0;
      shadow_diag[k] = clamp(shadow_diag[k-1] - prev, LIM_DIFF, unused);
      prev = cur;
    end
    shadow_coef[m] = shadow_diag[m];
    shadow_loaded = m + 1;
  endfunction

  function automatic interp_result_t interpolate(logic [31:0] xv);
    interp_result_t r;
    int             n;
    longint         x, dx, u, t, acc, f;
    longint unsigned h, q, tm;
    bit             sat;
    n = active_points();
    r = '{y: '0, ext: 1'b0, sat: 1'b0, not_ready: 1'b0};
    if (shadow_loaded < n) begin
      r.not_ready = 1'b1;
      return r;
    end
    x = sx32(xv);
    h = shadow_h == 0 ? 1 : shadow_h;
    dx = x - shadow_x0;
    q = (magnitude(dx) << FRAC_BITS) / h;
    sat = 1'b0;
    if (q > LIM_U) begin
      q = LIM_U;
      if (n >= 2) sat = 1'b1;
    end
    u = dx < 0 ? -longint'(q) : longint'(q);
    r.ext = (x < shadow_x0) || (x > shadow_x0 + longint'(n - 1) * longint'(h));
    t = 64'sd1 <<< FRAC_BITS;
    acc = shadow_coef[0];
    for (int k = 1; k < n; k++) begin
      f = u - (longint'(k - 1) <<< FRAC_BITS);
      t = q_mul(t, f, sat);
      tm = (magnitude(t) + k / 2) / k;
      t = t < 0 ? -longint'(tm) : longint'(tm);
      t = clamp(t, LIM_T, sat);
      acc = clamp(acc + q_mul(t, shadow_coef[k], sat), LIM_PROD, sat);
    end
    if (acc > 64'sh7FFFFFFF) begin
      acc = 64'sh7FFFFFFF;
      sat = 1'b1;
    end
    if (acc < -64'sh80000000) begin
      acc = -64'sh80000000;
      sat = 1'b1;
    end
    r.y = acc[31:0];
    r.sat = sat;
    return r;
  endfunction

  // Compare every result strobe with the oldest expectation.
  always @(posedge clk) begin
    interp_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result y=%h", y_result);
      end else begin
        want = pending_results.pop_front();
        if (y_result !== want.y || extrapolated !== want.ext || saturated !== want.sat ||
            status !== want.not_ready) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp y=%h ext=%0d sat=%0d st=%0d got y=%h ext=%0d sat=%0d st=%0d",
                     want.y, want.ext, want.sat, want.not_ready,
                     y_result, extrapolated, saturated, status);
        end
      end
    end
  end

  // Hold one item on the ports until it transfers, then update the shadow state.
  task automatic send_item(opcode_t op, logic [31:0] xv, logic [31:0] yv);
    start   <= 1'b1;
    opcode  <= op;
    x_value <= xv;
    y_value <= yv;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      OP_LOAD:    absorb_sample(yv);
      OP_EVAL:    pending_results.push_back(interpolate(xv));
      OP_RESTART: shadow_loaded = 0;
      default: ;
    endcase
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop start, wait for every expected result, then let trailing work finish.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on back-to-back cycles; call only after drain.
  task automatic set_config(logic [31:0] x0, logic [30:0] h, logic [4:0] n);
    cfg_we <= 1'b1;
    cfg_addr <= REG_X_ORIGIN;
    cfg_wdata <= x0;
    @(posedge clk);
    cfg_addr <= REG_STEP_H;
    cfg_wdata <= {1'b0, h};
    @(posedge clk);
    cfg_addr <= REG_POINT_COUNT;
    cfg_wdata <= {27'd0, n};
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_x0 = sx32(x0);
    shadow_h = h;
    shadow_count = n;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h000A0000) - 32'h00050000;
    endcase
  endfunction

  // Mostly land near the sampled grid; sometimes anywhere.
  function automatic logic [31:0] rand_query();
    longint k, frac, x;
    if ($urandom_range(9) == 0) return $urandom;
    k = longint'($urandom_range(0, active_points() + 1)) - 1;
    frac = longint'($urandom) % (shadow_h == 0 ? 1 : shadow_h);
    x = shadow_x0 + k * shadow_h + frac;
    return x[31:0];
  endfunction

  task automatic test_not_ready();
    send_item(OP_EVAL, $urandom, $urandom);
  endtask

  // Full 16-point table with extreme samples, queries at and beyond the ends.
  task automatic test_extreme_table();
    logic [31:0] ys [16] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF,
                             32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFF0000,
                             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                             32'h12345678, 32'hEDCBA987, 32'h0, 32'h55555555};
    foreach (ys[i]) send_item(OP_LOAD, $urandom, ys[i]);
    send_item(OP_EVAL, 32'h0, 32'h0);
    send_item(OP_EVAL, 32'h000F0000, 32'h0);
    send_item(OP_EVAL, 32'h00028000, 32'h0);
    send_item(OP_EVAL, 32'h7FFFFFFF, 32'h0);
    send_item(OP_EVAL, 32'h80000000, 32'h0);
    // Load when full: ignore the sample.
    send_item(OP_LOAD, 32'h0, 32'h11111111);
    send_item(OP_EVAL, 32'hFFFF8000, 32'h0);
    // Reserved opcode: no result.
    send_item(opcode_t'(2'd3), $urandom, $urandom);
  endtask

  // Count of zero, zero spacing, extreme origin, count above the limit.
  task automatic test_config_corners();
    drain();
    set_config(32'h80000000, 31'd0, 5'd0);
    send_item(OP_RESTART, $urandom, $urandom);
    send_item(OP_LOAD, 32'h0, 32'h00030000);
    send_item(OP_EVAL, 32'h80000000, 32'h0);
    send_item(OP_EVAL, 32'h7FFFFFFF, 32'h0);
    drain();
    set_config(32'h7FFFFFFF, 31'h7FFFFFFF, 5'd31);
    send_item(OP_RESTART, $urandom, $urandom);
    for (int i = 0; i < 16; i++) send_item(OP_LOAD, 32'h0, rand_sample());
    send_item(OP_EVAL, 32'h7FFFFFFF, 32'h0);
    send_item(OP_EVAL, 32'h0, 32'h0);
    // Shrink the count after loading: the first entries stay in use.
    drain();
    set_config(32'h7FFFFFFF, 31'd1, 5'd3);
    send_item(OP_EVAL, 32'h80000000, 32'h0);
    send_item(OP_EVAL, 32'h7FFFFFFF, 32'h0);
  endtask

  // Well-formed load/evaluate sequences with random content, plus noise.
  task automatic test_random_sequences(int item_goal);
    int sent;
    int loads;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(9) == 0) begin
        send_item(opcode_t'($urandom_range(3)), $urandom, $urandom);
        sent++;
        continue;
      end
      if ($urandom_range(4) == 0) begin
        drain();
        set_config($urandom_range(1) ? 32'($urandom_range(0, 32'h00200000)) - 32'h00100000
                                     : $urandom,
                   $urandom_range(4) == 0 ? 31'($urandom) :
                   $urandom_range(3) == 0 ? 31'($urandom_range(1, 3)) :
                   31'($urandom_range(32'h4000, 32'h40000)),
                   $urandom_range(5) == 0 ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(1, 6)));
      end
      send_item(OP_RESTART, $urandom, $urandom);
      loads = active_points() + ($urandom_range(5) == 0 ? 1 : 0);
      for (int i = 0; i < loads; i++) begin
        // A broken sequence now and then: query before the table is full.
        if ($urandom_range(19) == 0) send_item(OP_EVAL, rand_query(), $urandom);
        send_item(OP_LOAD, $urandom, rand_sample());
      end
      repeat ($urandom_range(2, 8)) send_item(OP_EVAL, rand_query(), $urandom);
      sent += loads + 6;
    end
  endtask

  initial begin
    shadow_x0 = 0;
    shadow_h = 65536;
    shadow_count = 16;
    shadow_loaded = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 13;
    test_not_ready();
    test_extreme_table();
    // Pause until all outstanding results are back.
    drain();
    test_config_corners();
    test_random_sequences(530);
    idle_pct = 84;
    test_random_sequences(530);
    idle_pct = 0;
    test_random_sequences(530);

    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
